@@ rtl/ps2mct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types, codes and constants of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int COORD_BITS = 13;
  localparam int DIM_BITS   = 14;
  localparam int TICK_BITS  = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(1) << COORD_BITS;

  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_CENTER = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLDOFF = 2'd2;

  localparam logic [1:0] PH_FLAGS = 2'd0;
  localparam logic [1:0] PH_X     = 2'd1;
  localparam logic [1:0] PH_Y     = 2'd2;

  localparam int FLAG_YOVF = 7;
  localparam int FLAG_XOVF = 6;
  localparam int FLAG_YSGN = 5;
  localparam int FLAG_XSGN = 4;
  localparam int FLAG_SYNC = 3;

  typedef struct packed {
    logic [DIM_BITS-1:0]  width;
    logic [DIM_BITS-1:0]  height;
    logic [TICK_BITS-1:0] holdoff;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            phase;
    logic                  discard;
    logic [7:0]            flag_byte;
    logic [7:0]            x_byte;
    logic [TICK_BITS-1:0]  tick_count;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
  } track_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  moved;
    logic                  packet_dropped;
    logic [1:0]            byte_phase;
  } result_t;

endpackage

@@ rtl/ps2mct_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_in_if
// Request channel: mouse byte, timer tick or recenter.
// ----------------------------------------------------------------------------
interface ps2mct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

@@ rtl/ps2mct_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_out_if
// Result channel: cursor position and packet status.
// ----------------------------------------------------------------------------
interface ps2mct_out_if;
  logic                              valid;
  logic                              ready;
  logic [ps2mct_pkg::COORD_BITS-1:0] cursor_x;
  logic [ps2mct_pkg::COORD_BITS-1:0] cursor_y;
  logic                              moved;
  logic                              packet_dropped;
  logic [1:0]                        byte_phase;

  modport source (output valid, output cursor_x, output cursor_y, output moved,
                  output packet_dropped, output byte_phase, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input moved,
                input packet_dropped, input byte_phase, output ready);
endinterface

@@ rtl/ps2mct_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface ps2mct_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ps2mct_pkg::CFG_IDX_BITS-1:0]  index;
  logic [ps2mct_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ps2mct_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_step
// Next tracker state and result for one request: hold-off, packet assembly,
// validity check, delta decode, clamped cursor move and recenter.
// ----------------------------------------------------------------------------
module ps2mct_step (
  input  ps2mct_pkg::cfg_t    cfg,
  input  ps2mct_pkg::track_t  cur,
  input  logic [1:0]          req_type,
  input  logic [7:0]          data_byte,
  output ps2mct_pkg::track_t  nxt,
  output ps2mct_pkg::result_t res
);

  logic [ps2mct_pkg::DIM_BITS-1:0] eff_w;
  logic [ps2mct_pkg::DIM_BITS-1:0] eff_h;
  logic                            bad_flags;
  logic signed [9:0]               dx;
  logic signed [9:0]               dy_neg;
  logic signed [15:0]              sum_x;
  logic signed [15:0]              sum_y;
  logic [ps2mct_pkg::DIM_BITS-1:0] lim_x;
  logic [ps2mct_pkg::DIM_BITS-1:0] lim_y;
  logic [ps2mct_pkg::COORD_BITS-1:0] new_x;
  logic [ps2mct_pkg::COORD_BITS-1:0] new_y;
  logic                            moved;
  logic                            dropped;

  always_comb begin
    if (cfg.width == '0) begin
      eff_w = ps2mct_pkg::DIM_BITS'(1);
    end else if (cfg.width > ps2mct_pkg::DIM_MAX) begin
      eff_w = ps2mct_pkg::DIM_MAX;
    end else begin
      eff_w = cfg.width;
    end
    if (cfg.height == '0) begin
      eff_h = ps2mct_pkg::DIM_BITS'(1);
    end else if (cfg.height > ps2mct_pkg::DIM_MAX) begin
      eff_h = ps2mct_pkg::DIM_MAX;
    end else begin
      eff_h = cfg.height;
    end
  end

  assign bad_flags = data_byte[ps2mct_pkg::FLAG_YOVF] | data_byte[ps2mct_pkg::FLAG_XOVF] |
                     ~data_byte[ps2mct_pkg::FLAG_SYNC];

  always_comb begin
    if (cur.flag_byte[ps2mct_pkg::FLAG_XSGN]) begin
      dx = 10'(signed'(cur.x_byte));
    end else begin
      dx = signed'({2'b00, cur.x_byte});
    end
    if (cur.flag_byte[ps2mct_pkg::FLAG_YSGN]) begin
      dy_neg = -10'(signed'(data_byte));
    end else begin
      dy_neg = -signed'({2'b00, data_byte});
    end
    sum_x = signed'(16'(cur.pos_x)) + 16'(dx);
    sum_y = signed'(16'(cur.pos_y)) + 16'(dy_neg);
    lim_x = eff_w - ps2mct_pkg::DIM_BITS'(1);
    lim_y = eff_h - ps2mct_pkg::DIM_BITS'(1);
    if (sum_x < 0) begin
      new_x = '0;
    end else if (sum_x >= signed'(16'(eff_w))) begin
      new_x = lim_x[ps2mct_pkg::COORD_BITS-1:0];
    end else begin
      new_x = sum_x[ps2mct_pkg::COORD_BITS-1:0];
    end
    if (sum_y < 0) begin
      new_y = '0;
    end else if (sum_y >= signed'(16'(eff_h))) begin
      new_y = lim_y[ps2mct_pkg::COORD_BITS-1:0];
    end else begin
      new_y = sum_y[ps2mct_pkg::COORD_BITS-1:0];
    end
  end

  always_comb begin
    nxt     = cur;
    moved   = 1'b0;
    dropped = 1'b0;
    case (req_type)
      ps2mct_pkg::REQ_TICK: begin
        if (cur.tick_count < cfg.holdoff) begin
          nxt.tick_count = cur.tick_count + ps2mct_pkg::TICK_BITS'(1);
        end
      end
      ps2mct_pkg::REQ_CENTER: begin
        nxt.pos_x = eff_w[ps2mct_pkg::DIM_BITS-1:1];
        nxt.pos_y = eff_h[ps2mct_pkg::DIM_BITS-1:1];
      end
      ps2mct_pkg::REQ_BYTE: begin
        if (cur.tick_count >= cfg.holdoff) begin
          case (cur.phase)
            ps2mct_pkg::PH_FLAGS: begin
              nxt.flag_byte = data_byte;
              nxt.phase     = ps2mct_pkg::PH_X;
              if (bad_flags) begin
                nxt.discard = 1'b1;
              end
            end
            ps2mct_pkg::PH_X: begin
              nxt.x_byte = data_byte;
              nxt.phase  = ps2mct_pkg::PH_Y;
            end
            default: begin
              nxt.phase = ps2mct_pkg::PH_FLAGS;
              if (cur.discard) begin
                nxt.discard = 1'b0;
                dropped     = 1'b1;
              end else begin
                nxt.pos_x = new_x;
                nxt.pos_y = new_y;
                moved     = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign res.cursor_x       = nxt.pos_x;
  assign res.cursor_y       = nxt.pos_y;
  assign res.moved          = moved;
  assign res.packet_dropped = dropped;
  assign res.byte_phase     = nxt.phase;

endmodule

@@ rtl/ps2_mouse_packet_cursor_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_top
// PS/2 mouse packet decoder with hold-off counter and clamped cursor.
//
// Channels: mouse carries one request item (mouse byte, timer tick or
// recenter); cursor returns exactly one result item per request with the
// cursor position, moved/dropped flags and the next expected byte index;
// cfg writes screen width (0), screen height (1) and hold-off ticks (2).
// cfg is always ready; write it only while the block is idle.
// A request accepted at an edge has its result registered and valid in the cycle
// after it. Throughput: one item per cycle while cursor takes each result, set
// by the result register, which is loaded together with the state update.
// When the cursor side stalls, the result register holds its item and mouse
// ready drops until that item is taken; ready returns in the same cycle as
// cursor ready rises.
// Reset: registers return to 1024 x 768 and 250 ticks, packet phase, tick
// count and cursor go to zero, and the result register empties.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_top (
  input logic                clk,
  input logic                rst,
  ps2mct_in_if.sink          mouse,
  ps2mct_out_if.source       cursor,
  ps2mct_cfg_if.sink         cfg
);

  ps2mct_pkg::cfg_t    regs;
  ps2mct_pkg::track_t  track;
  ps2mct_pkg::track_t  track_next;
  ps2mct_pkg::result_t res_next;
  ps2mct_pkg::result_t res;
  logic                res_valid;
  logic                take;

  assign mouse.ready = ~res_valid | cursor.ready;
  assign take        = mouse.valid & mouse.ready;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.width   <= ps2mct_pkg::DIM_BITS'(1024);
      regs.height  <= ps2mct_pkg::DIM_BITS'(768);
      regs.holdoff <= ps2mct_pkg::TICK_BITS'(250);
    end else if (cfg.valid) begin
      case (cfg.index)
        ps2mct_pkg::CFG_WIDTH:   regs.width   <= cfg.data[ps2mct_pkg::DIM_BITS-1:0];
        ps2mct_pkg::CFG_HEIGHT:  regs.height  <= cfg.data[ps2mct_pkg::DIM_BITS-1:0];
        ps2mct_pkg::CFG_HOLDOFF: regs.holdoff <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  ps2mct_step u_step (
    .cfg       (regs),
    .cur       (track),
    .req_type  (mouse.req_type),
    .data_byte (mouse.data_byte),
    .nxt       (track_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      track     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        track     <= track_next;
        res_valid <= 1'b1;
      end else if (cursor.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign cursor.valid          = res_valid;
  assign cursor.cursor_x       = res.cursor_x;
  assign cursor.cursor_y       = res.cursor_y;
  assign cursor.moved          = res.moved;
  assign cursor.packet_dropped = res.packet_dropped;
  assign cursor.byte_phase     = res.byte_phase;

endmodule
